FILE: src/ffha_pkg.sv
// Shared constants and types for the first-fit heap allocator.
package ffha_pkg;
  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 6;
  localparam int MAX_CHUNKS   = 256;
  localparam int SLOT_W       = 8;

  localparam logic [SLOT_W-1:0] ROOT_SLOT  = 8'd0;
  localparam logic [SLOT_W-1:0] MARK_SLOT  = 8'd1;
  localparam logic [SLOT_W-1:0] FIRST_SLOT = 8'd2;
  localparam logic [SLOT_W-1:0] LAST_SLOT  = 8'd255;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_UNKNOWN  = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic [12:0]       length;
    logic [11:0]       start;
    logic [SLOT_W-1:0] successor;
  } entry_t;
endpackage

FILE: src/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: sequencer over one chunk table RAM.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: cmd; tdata: request_bytes, release_offset
// m_*      out  m_tvalid/m_tready  tdata: status, payload_offset, gap_bytes, heap_end_offset
//
// An allocate searches slots 2 to 255 for a free one, walks the chain one entry at
// a time through the single table read port, then writes and links the new entry.
// A free walks the chain one entry at a time, then unlinks the matching entry.
// One item at a time; s_tready is high only while idle. A stalled result holds in
// the output register. rst is synchronous and clears the chain to root and marker.
module first_fit_heap_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // request_bytes[15:0], release_offset[27:16], zero pad
  input  logic        s_tuser,  // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // status[1:0], payload_offset[13:2], gap_bytes[26:14],
                                // heap_end_offset[39:27]
);
  typedef enum logic [2:0] {
    IDLE, FIND, WALK, FWALK, NEWW, LINK, RESP
  } state_t;

  state_t state;
  logic [ffha_pkg::MAX_CHUNKS-1:0] in_use;
  logic [ffha_pkg::SLOT_W-1:0] root_succ, idx, ns, cur_slot, cur_succ, link_val;
  logic [11:0] cur_start;
  logic [12:0] cur_len;
  logic [15:0] req;
  logic [11:0] off;
  logic [12:0] marker, end_mark, gap;
  logic [1:0]  res_status;
  logic [11:0] res_payload;
  logic [11:0] new_start;

  ffha_pkg::entry_t rd, wdata;
  logic we;
  logic [ffha_pkg::SLOT_W-1:0] waddr, raddr;

  logic [13:0] cur_end;
  logic [17:0] need, nm;
  logic [12:0] nxt_head;

  assign cur_end  = {2'd0, cur_start} + 14'(ffha_pkg::HEADER_BYTES) + {1'b0, cur_len};
  assign need     = {4'd0, cur_end} + 18'(ffha_pkg::HEADER_BYTES) + {2'd0, req};
  assign nm       = {5'd0, marker} + 18'(ffha_pkg::HEADER_BYTES) + {2'd0, req};
  assign nxt_head = (cur_succ == ffha_pkg::MARK_SLOT) ? marker : {1'b0, rd.start};

  assign raddr = (state == WALK || state == FWALK) ? rd.successor : root_succ;

  always_comb begin
    we    = 1'b0;
    waddr = ns;
    wdata = '{length: req[12:0], start: new_start, successor: link_val};
    if (state == NEWW) begin
      we = 1'b1;
    end else if (state == LINK) begin
      we    = (cur_slot != ffha_pkg::ROOT_SLOT);
      waddr = cur_slot;
      wdata = '{length: cur_len, start: cur_start, successor: link_val};
    end
  end

  ffha_ram #(.WIDTH($bits(ffha_pkg::entry_t)), .DEPTH(ffha_pkg::MAX_CHUNKS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd)
  );

  assign s_tready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      in_use     <= {{(ffha_pkg::MAX_CHUNKS-2){1'b0}}, 2'b11};
      root_succ  <= ffha_pkg::MARK_SLOT;
      marker     <= 13'(ffha_pkg::HEADER_BYTES);
      end_mark   <= '0;
      gap        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != RESP) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          cur_slot  <= ffha_pkg::ROOT_SLOT;
          cur_start <= '0;
          cur_len   <= '0;
          cur_succ  <= root_succ;
          idx       <= ffha_pkg::FIRST_SLOT;
          if (s_tvalid) begin
            req         <= s_tdata[15:0];
            off         <= s_tdata[27:16];
            res_payload <= '0;
            if (s_tuser == ffha_pkg::CMD_ALLOC) begin
              state <= FIND;
            end else begin
              state <= FWALK;
            end
          end
        end
        FIND: begin
          if (!in_use[idx]) begin
            ns    <= idx;
            state <= WALK;
          end else if (idx == ffha_pkg::LAST_SLOT) begin
            res_status <= ffha_pkg::ST_FULL;
            state      <= RESP;
          end else begin
            idx <= idx + 8'd1;
          end
        end
        WALK: begin
          if ({5'd0, nxt_head} >= need) begin
            new_start   <= cur_end[11:0];
            link_val    <= cur_succ;
            gap         <= gap - 13'(ffha_pkg::HEADER_BYTES) - req[12:0];
            res_payload <= 12'(cur_end + 14'(ffha_pkg::HEADER_BYTES));
            res_status  <= ffha_pkg::ST_OK;
            state       <= NEWW;
          end else if (cur_succ == ffha_pkg::MARK_SLOT) begin
            if (nm + 18'(ffha_pkg::HEADER_BYTES) > 18'(ffha_pkg::HEAP_BYTES)) begin
              res_status <= ffha_pkg::ST_NO_SPACE;
              state      <= RESP;
            end else begin
              new_start   <= marker[11:0];
              link_val    <= ffha_pkg::MARK_SLOT;
              marker      <= nm[12:0];
              end_mark    <= nm[12:0];
              res_payload <= 12'(marker + 13'(ffha_pkg::HEADER_BYTES));
              res_status  <= ffha_pkg::ST_OK;
              state       <= NEWW;
            end
          end else begin
            cur_slot  <= cur_succ;
            cur_start <= rd.start;
            cur_len   <= rd.length;
            cur_succ  <= rd.successor;
          end
        end
        FWALK: begin
          if (cur_succ == ffha_pkg::MARK_SLOT) begin
            res_status <= ffha_pkg::ST_UNKNOWN;
            state      <= RESP;
          end else if ({1'b0, rd.start} + 13'(ffha_pkg::HEADER_BYTES) == {1'b0, off}) begin
            link_val         <= rd.successor;
            in_use[cur_succ] <= 1'b0;
            gap              <= gap + 13'(ffha_pkg::HEADER_BYTES) + rd.length;
            res_status       <= ffha_pkg::ST_OK;
            state            <= LINK;
          end else begin
            cur_slot  <= cur_succ;
            cur_start <= rd.start;
            cur_len   <= rd.length;
            cur_succ  <= rd.successor;
          end
        end
        NEWW: begin
          in_use[ns] <= 1'b1;
          link_val   <= ns;
          state      <= LINK;
        end
        LINK: begin
          if (cur_slot == ffha_pkg::ROOT_SLOT) begin
            root_succ <= link_val;
          end
          state <= RESP;
        end
        RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {end_mark, gap, res_payload, res_status};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

FILE: src/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
